@@ design/irm_pkg.sv @@
// ----------------------------------------------------------------------------
// irm_pkg
// Shared types and constants for the ICMP reply matcher.
// ----------------------------------------------------------------------------
package irm_pkg;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_ID  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_SEQ = 1'b1;

    localparam logic [7:0] TYPE_ECHO_REPLY    = 8'd0;
    localparam logic [7:0] TYPE_TIME_EXCEEDED = 8'd11;

    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_ECHO  = 2'd1,
        KIND_TIMEX = 2'd2,
        KIND_OTHER = 2'd3
    } kind_t;

    localparam logic [1:0] REPLY_OTHER = 2'd0;

    typedef struct packed {
        logic [1:0]  reply_kind;
        logic        matched;
        logic [31:0] source_addr;
        logic        truncated;
    } report_t;

endpackage

@@ design/irm_if.sv @@
// ----------------------------------------------------------------------------
// irm_if
// Valid/ready channels for packet bytes in and match reports out.
// ----------------------------------------------------------------------------
interface irm_packet_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface irm_report_if;
    logic        valid;
    logic        ready;
    logic [1:0]  reply_kind;
    logic        matched;
    logic [31:0] source_addr;
    logic        truncated;

    modport source (output valid, output reply_kind, output matched,
                    output source_addr, output truncated, input ready);
    modport sink (input valid, input reply_kind, input matched,
                  input source_addr, input truncated, output ready);
endinterface

@@ design/irm_parser.sv @@
// ----------------------------------------------------------------------------
// irm_parser
// Per-packet header walk: tracks byte position, header lengths, ICMP kind and
// captured fields, and forms the report for the current beat.
// ----------------------------------------------------------------------------
module irm_parser #(
    parameter int MAX_PACKET_BYTES = 65535
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      step,
    input  logic [7:0]                data_byte,
    input  logic                      last_byte,
    input  logic [15:0]               expected_id,
    input  logic [15:0]               expected_seq,
    output irm_pkg::report_t          report
);
    import irm_pkg::*;

    localparam int POS_W = $clog2(MAX_PACKET_BYTES + 1);
    localparam int CMP_W = (POS_W > 8) ? POS_W : 8;
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_PACKET_BYTES);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [5:0]       ohl_reg, ohl_next;
    logic [5:0]       ihl_reg, ihl_next;
    kind_t            kind_reg, kind_next;
    logic [31:0]      src_reg, src_next;
    logic [15:0]      id_reg, id_next;
    logic [15:0]      seq_reg, seq_next;
    logic             done_reg, done_next;

    logic             in_range;
    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] type_off;
    logic [CMP_W-1:0] inner_off;
    logic [CMP_W-1:0] base;
    logic             known;

    always_comb
    begin
        in_range  = pos_reg < POS_MAX;
        pos_ext   = CMP_W'(pos_reg);
        pos_next  = pos_reg;
        ohl_next  = ohl_reg;
        ihl_next  = ihl_reg;
        kind_next = kind_reg;
        src_next  = src_reg;
        id_next   = id_reg;
        seq_next  = seq_reg;
        done_next = done_reg;

        if (in_range && pos_reg == '0)
        begin
            ohl_next = {data_byte[3:0], 2'b00};
        end
        type_off  = CMP_W'(ohl_next);
        inner_off = CMP_W'(ohl_next) + CMP_W'(8);

        if (in_range && pos_reg >= POS_W'(12) && pos_reg <= POS_W'(15))
        begin
            src_next = {src_reg[23:0], data_byte};
        end

        if (in_range && pos_ext == type_off)
        begin
            if (data_byte == TYPE_ECHO_REPLY)
            begin
                kind_next = KIND_ECHO;
            end
            else if (data_byte == TYPE_TIME_EXCEEDED)
            begin
                kind_next = KIND_TIMEX;
            end
            else
            begin
                kind_next = KIND_OTHER;
            end
        end

        if (in_range && kind_next == KIND_TIMEX && pos_ext == inner_off)
        begin
            ihl_next = {data_byte[3:0], 2'b00};
        end

        known = (kind_next == KIND_ECHO) || (kind_next == KIND_TIMEX);
        if (kind_next == KIND_ECHO)
        begin
            base = type_off + CMP_W'(4);
        end
        else
        begin
            base = inner_off + CMP_W'(ihl_next) + CMP_W'(4);
        end

        if (in_range && known && !done_reg)
        begin
            if (pos_ext == base)
            begin
                id_next = {data_byte, id_reg[7:0]};
            end
            else if (pos_ext == base + CMP_W'(1))
            begin
                id_next = {id_reg[15:8], data_byte};
            end
            else if (pos_ext == base + CMP_W'(2))
            begin
                seq_next = {data_byte, seq_reg[7:0]};
            end
            else if (pos_ext == base + CMP_W'(3))
            begin
                seq_next  = {seq_reg[15:8], data_byte};
                done_next = 1'b1;
            end
        end

        if (in_range)
        begin
            pos_next = pos_reg + POS_W'(1);
        end

        report.reply_kind  = (kind_next == KIND_OTHER) ? REPLY_OTHER : kind_next;
        report.matched     = known && done_next && id_next == expected_id
                             && seq_next == expected_seq;
        report.source_addr = src_next;
        report.truncated   = (kind_next == KIND_NONE) || (known && !done_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            ohl_reg  <= '0;
            ihl_reg  <= '0;
            kind_reg <= KIND_NONE;
            src_reg  <= '0;
            id_reg   <= '0;
            seq_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (step)
        begin
            if (last_byte)
            begin
                pos_reg  <= '0;
                ohl_reg  <= '0;
                ihl_reg  <= '0;
                kind_reg <= KIND_NONE;
                src_reg  <= '0;
                id_reg   <= '0;
                seq_reg  <= '0;
                done_reg <= 1'b0;
            end
            else
            begin
                pos_reg  <= pos_next;
                ohl_reg  <= ohl_next;
                ihl_reg  <= ihl_next;
                kind_reg <= kind_next;
                src_reg  <= src_next;
                id_reg   <= id_next;
                seq_reg  <= seq_next;
                done_reg <= done_next;
            end
        end
    end

endmodule

@@ design/icmp_reply_matcher_top.sv @@
// ----------------------------------------------------------------------------
// icmp_reply_matcher_top
// Parses a received IPv4 packet byte by byte and reports, on the last byte,
// the ICMP reply kind, an id/sequence match and the outer source address.
//
//   channel   dir   beat payload
//   packet    in    data_byte[7:0], last_byte
//   report    out   reply_kind[1:0], matched, source_addr[31:0], truncated
//   cfg       in    cfg_index selects expected_id / expected_seq
//
// One byte per cycle sustained while no final byte is held; each byte passes through
// the input register, and a final byte's report is registered in the output register.
// Reset clears all packet state and both expected values to zero.
// A non-final byte never waits on the report side; a final byte holds in the
// input register while the previous report is still untaken.
// ----------------------------------------------------------------------------
module icmp_reply_matcher_top #(
    parameter int MAX_PACKET_BYTES = 65535
) (
    input  logic                            clk,
    input  logic                            rst_n,
    irm_packet_if.sink                      packet,
    irm_report_if.source                    report,
    input  logic                            cfg_wr_en,
    input  logic [irm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [irm_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import irm_pkg::*;

    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_last_reg;
    logic       s1_go;
    logic       out_free;

    logic       out_valid_reg;
    report_t    out_reg;
    report_t    parse_report;

    logic [15:0] exp_id_reg;
    logic [15:0] exp_seq_reg;

    assign out_free     = !out_valid_reg || report.ready;
    assign s1_go        = s1_valid_reg && (!s1_last_reg || out_free);
    assign packet.ready = !s1_valid_reg || s1_go;

    irm_parser #(
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
    ) u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (s1_go),
        .data_byte    (s1_byte_reg),
        .last_byte    (s1_last_reg),
        .expected_id  (exp_id_reg),
        .expected_seq (exp_seq_reg),
        .report       (parse_report)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            exp_id_reg    <= '0;
            exp_seq_reg   <= '0;
        end
        else
        begin
            if (packet.ready)
            begin
                s1_valid_reg <= packet.valid;
            end
            if (s1_go && s1_last_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (report.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_EXPECTED_ID:  exp_id_reg  <= cfg_wdata;
                    CFG_EXPECTED_SEQ: exp_seq_reg <= cfg_wdata;
                    default:          ;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (packet.valid && packet.ready)
        begin
            s1_byte_reg <= packet.data_byte;
            s1_last_reg <= packet.last_byte;
        end
        if (s1_go && s1_last_reg)
        begin
            out_reg <= parse_report;
        end
    end

    assign report.valid       = out_valid_reg;
    assign report.reply_kind  = out_reg.reply_kind;
    assign report.matched     = out_reg.matched;
    assign report.source_addr = out_reg.source_addr;
    assign report.truncated   = out_reg.truncated;

endmodule

@@ design/irm_checker.sv @@
// ----------------------------------------------------------------------------
// irm_checker
// Port-level checks on the report channel of the ICMP reply matcher.
// ----------------------------------------------------------------------------
module irm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        rpt_valid,
    input logic        rpt_ready,
    input logic [1:0]  rpt_kind,
    input logic        rpt_matched,
    input logic [31:0] rpt_source,
    input logic        rpt_truncated
);
    import irm_pkg::*;

    a_valid_holds : assert property (
        @(posedge clk) disable iff (!rst_n)
        rpt_valid && !rpt_ready |=> rpt_valid
    ) else $error("report beat dropped while stalled");

    a_payload_holds : assert property (
        @(posedge clk) disable iff (!rst_n)
        rpt_valid && !rpt_ready |=> $stable({rpt_kind, rpt_matched, rpt_source, rpt_truncated})
    ) else $error("report payload changed while stalled");

    a_kind_legal : assert property (
        @(posedge clk) disable iff (!rst_n)
        rpt_valid |-> rpt_kind != KIND_OTHER
    ) else $error("report kind out of range");

    a_match_consistent : assert property (
        @(posedge clk) disable iff (!rst_n)
        rpt_valid && rpt_matched |-> !rpt_truncated && rpt_kind != KIND_NONE
    ) else $error("match reported on truncated or unknown reply");

endmodule

bind icmp_reply_matcher_top irm_checker u_irm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .rpt_valid     (report.valid),
    .rpt_ready     (report.ready),
    .rpt_kind      (report.reply_kind),
    .rpt_matched   (report.matched),
    .rpt_source    (report.source_addr),
    .rpt_truncated (report.truncated)
);

@@ dv/icmp_reply_matcher_top_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icmp_reply_matcher_top_test
// Drives IPv4 packets into the ICMP reply matcher a byte per beat and checks
// every report against a byte-level parser kept in the bench. Directed
// packets cover echo replies, time exceeded, other types, short headers and
// truncation. Random packets follow, in phases with fresh expected
// id/sequence values and, in phases 0, 1 and 3, random stalls on both channels.
// ----------------------------------------------------------------------------
module icmp_reply_matcher_top_test;
    import irm_pkg::*;

    localparam int MAX_BYTES   = 65535;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE      = 4;

    logic clk;
    logic rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    irm_packet_if pkt_if ();
    irm_report_if rpt_if ();

    icmp_reply_matcher_top #(
        .MAX_PACKET_BYTES(MAX_BYTES)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .packet   (pkt_if),
        .report   (rpt_if),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    // parser state and expected values
    int          p_pos;
    int          p_ohl;
    int          p_ihl;
    kind_t       p_kind;
    logic [31:0] p_src;
    logic [15:0] p_id;
    logic [15:0] p_seq;
    bit          p_done;
    logic [15:0] want_id;
    logic [15:0] want_seq;

    report_t     expected_reports[$];
    logic [7:0]  pkt_bytes[$];

    int  errors;
    int  beats_sent;
    int  packets_sent;
    int  n_echo, n_timex, n_other, n_trunc, n_match;
    bit  idle_en;
    int  stall_left;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("icmp_reply_matcher_top verification failed");
        $finish;
    end

    task automatic report_mismatch(input string what);
        if (errors < 30)
            $display("MISMATCH at %0t: %s", $realtime, what);
        errors++;
    endtask

    function automatic void clear_parser();
        p_pos  = 0;
        p_ohl  = 0;
        p_ihl  = 0;
        p_kind = KIND_NONE;
        p_src  = '0;
        p_id   = '0;
        p_seq  = '0;
        p_done = 1'b0;
    endfunction

    function automatic bit parse_byte(input logic [7:0] b, input logic fin,
                                      output report_t rep);
        int base;
        bit known;
        rep = '0;
        if (p_pos < MAX_BYTES)
        begin
            if (p_pos == 0)
                p_ohl = int'(b[3:0]) * 4;
            if (p_pos >= 12 && p_pos <= 15)
                p_src = {p_src[23:0], b};
            if (p_pos == p_ohl)
            begin
                if (b == TYPE_ECHO_REPLY)
                    p_kind = KIND_ECHO;
                else if (b == TYPE_TIME_EXCEEDED)
                    p_kind = KIND_TIMEX;
                else
                    p_kind = KIND_OTHER;
            end
            if (p_kind == KIND_TIMEX && p_pos == p_ohl + 8)
                p_ihl = int'(b[3:0]) * 4;
            if ((p_kind == KIND_ECHO || p_kind == KIND_TIMEX) && !p_done)
            begin
                base = (p_kind == KIND_ECHO) ? p_ohl + 4 : p_ohl + 12 + p_ihl;
                if (p_pos == base)
                    p_id[15:8] = b;
                else if (p_pos == base + 1)
                    p_id[7:0] = b;
                else if (p_pos == base + 2)
                    p_seq[15:8] = b;
                else if (p_pos == base + 3)
                begin
                    p_seq[7:0] = b;
                    p_done     = 1'b1;
                end
            end
            p_pos++;
        end
        if (!fin)
            return 1'b0;
        known = (p_kind == KIND_ECHO || p_kind == KIND_TIMEX);
        rep.reply_kind  = (p_kind == KIND_OTHER) ? REPLY_OTHER : p_kind;
        rep.matched     = known && p_done && p_id == want_id && p_seq == want_seq;
        rep.source_addr = p_src;
        rep.truncated   = (p_kind == KIND_NONE) || (known && !p_done);
        clear_parser();
        return 1'b1;
    endfunction

    // result side: random stall bursts on ready
    initial
    begin
        rpt_if.ready <= 1'b0;
        stall_left = 0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                rpt_if.ready <= 1'b0;
            end
            else if (idle_en && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 16) - 1;
                rpt_if.ready <= 1'b0;
            end
            else
                rpt_if.ready <= 1'b1;
        end
    end

    task automatic check_report(input report_t got);
        report_t want;
        if (expected_reports.size() == 0)
        begin
            report_mismatch("report beat with nothing expected");
            return;
        end
        want = expected_reports.pop_front();
        if (got.reply_kind !== want.reply_kind)
            report_mismatch($sformatf("reply_kind got %0d want %0d",
                                      got.reply_kind, want.reply_kind));
        if (got.matched !== want.matched)
            report_mismatch($sformatf("matched got %0b want %0b",
                                      got.matched, want.matched));
        if (got.source_addr !== want.source_addr)
            report_mismatch($sformatf("source_addr got %08h want %08h",
                                      got.source_addr, want.source_addr));
        if (got.truncated !== want.truncated)
            report_mismatch($sformatf("truncated got %0b want %0b",
                                      got.truncated, want.truncated));
        if (want.reply_kind == KIND_ECHO)
            n_echo++;
        else if (want.reply_kind == KIND_TIMEX)
            n_timex++;
        else
            n_other++;
        n_trunc += want.truncated;
        n_match += want.matched;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && rpt_if.valid && rpt_if.ready)
            check_report({rpt_if.reply_kind, rpt_if.matched,
                          rpt_if.source_addr, rpt_if.truncated});
    end

    task automatic send_beat(input logic [7:0] b, input logic fin);
        report_t rep;
        if (idle_en && $urandom_range(0, 9) == 0)
        begin
            pkt_if.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        pkt_if.valid     <= 1'b1;
        pkt_if.data_byte <= b;
        pkt_if.last_byte <= fin;
        do
            @(posedge clk);
        while (!pkt_if.ready);
        beats_sent++;
        if (parse_byte(b, fin, rep))
            expected_reports.push_back(rep);
    endtask

    task automatic send_packet();
        for (int i = 0; i < pkt_bytes.size(); i++)
            send_beat(pkt_bytes[i], i == pkt_bytes.size() - 1);
        packets_sent++;
    endtask

    // hold input low until every report is back, then let the pipe settle
    task automatic wait_idle();
        pkt_if.valid <= 1'b0;
        while (expected_reports.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        wait_idle();
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_EXPECTED_ID)
            want_id = value;
        else
            want_seq = value;
    endtask

    function automatic void fill_random(input int len);
        pkt_bytes.delete();
        for (int i = 0; i < len; i++)
            pkt_bytes.push_back(8'($urandom));
    endfunction

    function automatic void make_echo(input int nib, input logic [15:0] id,
                                      input logic [15:0] seq, input int extra);
        int ohl;
        ohl = nib * 4;
        fill_random(((ohl + 8 > 16) ? ohl + 8 : 16) + extra);
        pkt_bytes[0]       = {4'h4, 4'(nib)};
        pkt_bytes[ohl]     = TYPE_ECHO_REPLY;
        pkt_bytes[ohl + 4] = id[15:8];
        pkt_bytes[ohl + 5] = id[7:0];
        pkt_bytes[ohl + 6] = seq[15:8];
        pkt_bytes[ohl + 7] = seq[7:0];
    endfunction

    function automatic void make_timex(input int nib, input int inib,
                                       input logic [15:0] id,
                                       input logic [15:0] seq, input int extra);
        int ohl;
        int base;
        ohl  = nib * 4;
        base = ohl + 12 + inib * 4;
        fill_random(((base + 4 > 16) ? base + 4 : 16) + extra);
        pkt_bytes[0]        = {4'h4, 4'(nib)};
        pkt_bytes[ohl]      = TYPE_TIME_EXCEEDED;
        pkt_bytes[ohl + 8]  = {4'h4, 4'(inib)};
        pkt_bytes[base]     = id[15:8];
        pkt_bytes[base + 1] = id[7:0];
        pkt_bytes[base + 2] = seq[15:8];
        pkt_bytes[base + 3] = seq[7:0];
    endfunction

    function automatic void cut_packet(input int len);
        while (pkt_bytes.size() > len)
            void'(pkt_bytes.pop_back());
    endfunction

    task automatic test_reset_values();
        make_echo(5, 16'h0000, 16'h0000, 0);
        send_packet();
        make_timex(5, 5, 16'h0000, 16'h0000, 2);
        send_packet();
    endtask

    task automatic test_echo_reply();
        write_reg(CFG_EXPECTED_ID, 16'hFFFF);
        write_reg(CFG_EXPECTED_SEQ, 16'hFFFF);
        make_echo(5, 16'hFFFF, 16'hFFFF, 0);
        send_packet();
        make_echo(15, 16'hFFFF, 16'hFFFE, 3);
        send_packet();
    endtask

    task automatic test_time_exceeded();
        write_reg(CFG_EXPECTED_ID, 16'h1234);
        write_reg(CFG_EXPECTED_SEQ, 16'h00A5);
        make_timex(5, 5, 16'h1234, 16'h00A5, 0);
        send_packet();
        make_timex(15, 15, 16'h1234, 16'h00A5, 1);
        send_packet();
        make_timex(6, 0, 16'h1235, 16'h00A5, 0);
        send_packet();
    endtask

    task automatic test_other_type();
        make_echo(5, want_id, want_seq, 0);
        pkt_bytes[20] = 8'hFF;
        send_packet();
    endtask

    task automatic test_short_header();
        // zero length: byte 0 is the type itself
        make_echo(0, want_id, want_seq, 0);
        send_packet();
        make_echo(2, want_id, want_seq, 0);
        send_packet();
        make_timex(1, 3, want_id, want_seq, 0);
        send_packet();
    endtask

    task automatic test_truncation();
        pkt_bytes.delete();
        pkt_bytes.push_back(8'hFF);
        send_packet();
        make_echo(5, want_id, want_seq, 0);
        cut_packet(10);
        send_packet();
        make_echo(5, want_id, want_seq, 0);
        cut_packet(22);
        send_packet();
        make_timex(5, 5, want_id, want_seq, 0);
        cut_packet(40);
        send_packet();
        // echo complete but source address cut short
        make_echo(0, want_id, want_seq, 0);
        cut_packet(14);
        send_packet();
    endtask

    task automatic random_packet();
        int          r;
        int          nib;
        logic [15:0] id;
        logic [15:0] seq;
        r   = $urandom_range(0, 99);
        id  = want_id;
        seq = want_seq;
        case ($urandom_range(0, 3))
            2:
            begin
                id  = 16'($urandom);
                seq = 16'($urandom);
            end
            3:
            begin
                if ($urandom_range(0, 1))
                    id[$urandom_range(0, 15)] ^= 1'b1;
                else
                    seq[$urandom_range(0, 15)] ^= 1'b1;
            end
            default: ;
        endcase
        nib = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 15);
        if (r < 40)
            make_echo(($urandom_range(0, 19) == 0) ? 0 : nib, id, seq,
                      $urandom_range(0, 6));
        else if (r < 85)
            make_timex(nib, ($urandom_range(0, 1)) ? 5 : $urandom_range(0, 15), id, seq,
                       $urandom_range(0, 6));
        else
        begin
            fill_random($urandom_range(1, 48));
            if ($urandom_range(0, 1))
                pkt_bytes[0] = {4'h4, 4'($urandom_range(0, 15))};
        end
        if (r >= 70 && r < 85)
            cut_packet($urandom_range(1, pkt_bytes.size()));
        send_packet();
    endtask

    task automatic test_random();
        int start_beats;
        int start_reports;
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0:
                begin
                    write_reg(CFG_EXPECTED_ID, 16'hFFFF);
                    write_reg(CFG_EXPECTED_SEQ, 16'h0000);
                end
                1:
                begin
                    write_reg(CFG_EXPECTED_ID, 16'h0000);
                    write_reg(CFG_EXPECTED_SEQ, 16'hFFFF);
                end
                default:
                begin
                    write_reg(CFG_EXPECTED_ID, 16'($urandom));
                    write_reg(CFG_EXPECTED_SEQ, 16'($urandom));
                end
            endcase
            // no idling in phases 2 and 4
            idle_en = (ph == 2 || ph == 4) ? 1'b0 : 1'b1;
            start_beats   = beats_sent;
            start_reports = packets_sent;
            while (beats_sent - start_beats < 150 || packets_sent - start_reports < 2)
                random_packet();
        end
    endtask

    initial
    begin
        int drain;
        rst_n            <= 1'b0;
        pkt_if.valid     <= 1'b0;
        pkt_if.data_byte <= '0;
        pkt_if.last_byte <= 1'b0;
        cfg_wr_en        <= 1'b0;
        cfg_index        <= '0;
        cfg_wdata        <= '0;
        errors       = 0;
        beats_sent   = 0;
        packets_sent = 0;
        n_echo = 0; n_timex = 0; n_other = 0; n_trunc = 0; n_match = 0;
        want_id  = '0;
        want_seq = '0;
        idle_en  = 1'b1;
        clear_parser();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_values();
        test_echo_reply();
        test_time_exceeded();
        test_other_type();
        test_short_header();
        test_truncation();
        test_random();

        pkt_if.valid <= 1'b0;
        drain = 0;
        while (expected_reports.size() != 0 && drain < 20000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (8) @(posedge clk);
        if (expected_reports.size() != 0)
            report_mismatch($sformatf("%0d reports never arrived",
                                      expected_reports.size()));

        $display("Sent %0d bytes in %0d packets; reports: %0d echo, %0d time exceeded,",
                 beats_sent, packets_sent, n_echo, n_timex);
        $display("  %0d other, %0d truncated, %0d matched; %0d mismatches",
                 n_other, n_trunc, n_match, errors);
        if (errors == 0)
            $display("icmp_reply_matcher_top verification clean");
        else
            $display("icmp_reply_matcher_top verification failed");
        $finish;
    end

endmodule
